// File: design/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_ESCAPE  = 3'd1,
		MODE_HEX_HI  = 3'd2,
		MODE_WANT_BS = 3'd3,
		MODE_WANT_U  = 3'd4,
		MODE_HEX_LO  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_UNTERM_STR   = 3'd1;
	localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
	localparam logic [2:0] ERR_BAD_ESC      = 3'd3;
	localparam logic [2:0] ERR_TRUNC_U      = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
	localparam logic [2:0] ERR_MISSING_LOW  = 3'd6;
	localparam logic [2:0] ERR_BAD_LOW      = 3'd7;

	localparam int GQ_DEPTH = 4;
	localparam int GQ_AW    = $clog2(GQ_DEPTH);
	localparam int GQ_CW    = $clog2(GQ_DEPTH + 1);

	typedef struct packed {
		mode_t        mode;
		logic [1:0]   cnt;
		logic [15:0]  acc;
		logic [9:0]   hs;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic [2:0] code;
	} result_t;

	typedef struct packed {
		logic [1:0]         last_idx;
		result_t [3:0]      res;
	} group_t;

	typedef struct packed {
		logic [2:0]       n;
		logic [3:0][7:0]  b;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= "0" && c <= "9") begin
			h.val = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			h.val = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t u;
		u = '0;
		if (cp <= 21'h7F) begin
			u.n    = 3'd1;
			u.b[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			u.n    = 3'd2;
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			u.n    = 3'd3;
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
		end else begin
			u.n    = 3'd4;
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

endpackage

// File: design/json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps

// JSON string body decoder. Feed the bytes after the opening quote, one per
// transaction; a transaction with text_ended set closes the text. Results come
// out one per transaction: data bytes (escapes resolved, \u code points as
// UTF-8), then an end result on the closing quote or an error result with its
// code; last marks the final result of each input byte. Each byte is decoded
// combinationally between the input register and a four-entry result group
// queue; input flows at one byte per cycle while the queue has room. The
// output port moves one result per cycle unless result_stall is high, so a
// code point that expands to two to four UTF-8 bytes gives one result per
// byte, and the input stalls once the group queue fills.

module json_string_unescape_utf8_core import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  byte_value,
	input  logic        text_ended,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [2:0]  error_code,
	output logic        last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ended_s1;
	logic       q_ready;
	logic       fire;
	logic       grp_valid;
	group_t     grp;

	assign fire       = valid_s1 && q_ready;
	assign item_stall = valid_s1 && !q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			byte_s1  <= byte_value;
			ended_s1 <= text_ended;
		end
	end

	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.ended_s1  (ended_s1),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	jsu_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire && grp_valid),
		.push_grp     (grp),
		.ready        (q_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.error_code   (error_code),
		.last         (last)
	);

endmodule

// File: design/jsu_decode.sv
`timescale 1ns / 1ps

module jsu_decode import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_s1,
	input  logic        ended_s1,
	output logic        grp_valid,
	output group_t      grp
);

	dec_state_t st_q;
	dec_state_t nxt;
	logic [2:0]  n;
	hex_t        hv;
	logic [15:0] acc_new;
	logic [20:0] cp_pair;
	utf8_t       enc;
	logic        emit;
	logic [20:0] emit_cp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_PLAIN, cnt: '0, acc: '0, hs: '0};
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	assign hv      = hex_val(byte_s1);
	assign acc_new = {st_q.acc[11:0], hv.val};
	assign cp_pair = 21'h10000 + {1'b0, st_q.hs, acc_new[9:0]};
	assign enc     = utf8_enc(emit_cp);

	always_comb begin
		nxt     = st_q;
		n       = 3'd0;
		grp     = '0;
		emit    = 1'b0;
		emit_cp = {5'd0, acc_new};
		if (ended_s1) begin
			n               = 3'd1;
			grp.res[0].kind = KIND_ERROR;
			case (st_q.mode)
				MODE_PLAIN:               grp.res[0].code = ERR_UNTERM_STR;
				MODE_ESCAPE:              grp.res[0].code = ERR_UNTERM_ESC;
				MODE_HEX_HI, MODE_HEX_LO: grp.res[0].code = ERR_TRUNC_U;
				default:                  grp.res[0].code = ERR_MISSING_LOW;
			endcase
		end else begin
			case (st_q.mode)
				MODE_PLAIN: begin
					if (byte_s1 == "\"") begin
						n               = 3'd1;
						grp.res[0].kind = KIND_END;
					end else if (byte_s1 == "\\") begin
						nxt.mode = MODE_ESCAPE;
					end else begin
						n               = 3'd1;
						grp.res[0].data = byte_s1;
					end
				end
				MODE_ESCAPE: begin
					n        = 3'd1;
					nxt.mode = MODE_PLAIN;
					case (byte_s1)
						"\"", "\\", "/": grp.res[0].data = byte_s1;
						"b":             grp.res[0].data = 8'h08;
						"f":             grp.res[0].data = 8'h0C;
						"n":             grp.res[0].data = 8'h0A;
						"r":             grp.res[0].data = 8'h0D;
						"t":             grp.res[0].data = 8'h09;
						"u": begin
							n        = 3'd0;
							nxt.mode = MODE_HEX_HI;
							nxt.cnt  = 2'd0;
							nxt.acc  = 16'd0;
						end
						default: begin
							grp.res[0].kind = KIND_ERROR;
							grp.res[0].code = ERR_BAD_ESC;
						end
					endcase
				end
				MODE_WANT_BS: begin
					if (byte_s1 == "\\") begin
						nxt.mode = MODE_WANT_U;
					end else begin
						n               = 3'd1;
						grp.res[0].kind = KIND_ERROR;
						grp.res[0].code = ERR_MISSING_LOW;
					end
				end
				MODE_WANT_U: begin
					if (byte_s1 == "u") begin
						nxt.mode = MODE_HEX_LO;
						nxt.cnt  = 2'd0;
						nxt.acc  = 16'd0;
					end else begin
						n               = 3'd1;
						grp.res[0].kind = KIND_ERROR;
						grp.res[0].code = ERR_MISSING_LOW;
					end
				end
				MODE_HEX_HI, MODE_HEX_LO: begin
					if (!hv.ok) begin
						n               = 3'd1;
						grp.res[0].kind = KIND_ERROR;
						grp.res[0].code = ERR_BAD_HEX;
					end else if (st_q.cnt != 2'd3) begin
						nxt.acc = acc_new;
						nxt.cnt = st_q.cnt + 2'd1;
					end else if (st_q.mode == MODE_HEX_HI) begin
						if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
							nxt.mode = MODE_WANT_BS;
							nxt.cnt  = 2'd0;
							nxt.acc  = 16'd0;
							nxt.hs   = acc_new[9:0];
						end else begin
							emit = 1'b1;
						end
					end else begin
						if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
							emit    = 1'b1;
							emit_cp = cp_pair;
						end else begin
							n               = 3'd1;
							grp.res[0].kind = KIND_ERROR;
							grp.res[0].code = ERR_BAD_LOW;
						end
					end
				end
				default: begin
					nxt.mode = MODE_PLAIN;
				end
			endcase
		end
		if (emit) begin
			n = enc.n;
			for (int i = 0; i < 4; i++) begin
				grp.res[i].data = enc.b[i];
			end
		end
		if (emit || (n != 3'd0 && grp.res[0].kind != KIND_DATA) || st_q.mode > MODE_HEX_LO) begin
			nxt = '{mode: MODE_PLAIN, cnt: '0, acc: '0, hs: '0};
		end
		grp.last_idx = 2'(n - 3'd1);
	end

	assign grp_valid = (n != 3'd0);

endmodule

// File: design/jsu_out_queue.sv
`timescale 1ns / 1ps

module jsu_out_queue import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  group_t      push_grp,
	output logic        ready,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [2:0]  error_code,
	output logic        last
);

	group_t           mem_q [GQ_DEPTH];
	logic [GQ_AW-1:0] wr_ptr_q;
	logic [GQ_AW-1:0] rd_ptr_q;
	logic [GQ_CW-1:0] count_q;
	logic [1:0]       idx_q;
	group_t           head;
	result_t          cur;
	logic             take;
	logic             pop;

	assign head         = mem_q[rd_ptr_q];
	assign cur          = head.res[idx_q];
	assign result_valid = (count_q != '0);
	assign ready        = (count_q != GQ_CW'(GQ_DEPTH));
	assign take         = result_valid && !result_stall;
	assign last         = (idx_q == head.last_idx);
	assign pop          = take && last;

	assign out_byte   = cur.data;
	assign kind       = cur.kind;
	assign error_code = cur.code;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= GQ_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= GQ_AW'(rd_ptr_q + 1'b1);
				idx_q    <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/jsu_checker.sv
`timescale 1ns / 1ps

module jsu_checker import jsu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [7:0]  out_byte,
	input logic [1:0]  kind,
	input logic [2:0]  error_code,
	input logic        last
);

	// end and error results close their group and carry no byte
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_END |-> last && out_byte == 8'd0 && error_code == ERR_NONE)
		else $error("end result malformed");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ERROR |-> last && out_byte == 8'd0 && error_code != ERR_NONE)
		else $error("error result malformed");

	a_data_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_DATA |-> error_code == ERR_NONE)
		else $error("data result with error code");

	// a multi-byte sequence continues with continuation bytes
	a_utf8_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && kind == KIND_DATA && !last
		|=> result_valid && kind == KIND_DATA && out_byte[7:6] == 2'b10)
		else $error("broken UTF-8 sequence");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall
		|=> result_valid && $stable(out_byte) && $stable(kind) && $stable(last))
		else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.out_byte     (out_byte),
	.kind         (kind),
	.error_code   (error_code),
	.last         (last)
);
